@@ rtl/core/lbws_pkg.sv @@
// Shared types and codes for the least-busy worker selector.
// Used by lbws_table, lbws_seq and least_busy_worker_select_top.
package lbws_pkg;

  localparam int unsigned MASK_W   = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TIER_W   = 4;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned BUSY_W   = 16;
  localparam int unsigned STATUS_W = 32;
  localparam int unsigned ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_SELECT = 2'd1,
    REQ_RESET  = 2'd2
  } lbws_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_CLR,
    S_MAX,
    S_PASS,
    S_FIN,
    S_OUT
  } lbws_state_t;

  typedef struct packed {
    lbws_req_t           req_type;
    logic [SLOT_W-1:0]   worker_slot;
    logic [TIER_W-1:0]   tier;
    logic [WEIGHT_W-1:0] weight;
    logic [BUSY_W-1:0]   busy_count;
    logic                is_standby;
    logic                is_draining;
    logic                is_usable;
    logic [MASK_W-1:0]   prefer_mask;
    logic [MASK_W-1:0]   allow_mask;
  } lbws_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                standby;
    logic                draining;
    logic                usable;
  } lbws_stat_t;

  typedef struct packed {
    logic [BUSY_W-1:0]   busy;
    logic [STATUS_W-1:0] status;
  } lbws_dyn_t;

  typedef struct packed {
    logic stat_we;
    logic dyn_we;
    logic clr;
  } lbws_wr_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   worker;
    logic [STATUS_W-1:0] status;
  } lbws_res_t;

endpackage

@@ rtl/core/lbws_table.sv @@
// Worker table: static entry memory and busy/status memory, registered read.
// Valid bits stand in for the cleared state. Depends on lbws_pkg.
module lbws_table #(
  parameter int MAX_WORKERS = 16,
  parameter int TIER_BITS   = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lbws_pkg::lbws_wr_t                    wr_i,
  input  logic [$clog2(MAX_WORKERS)-1:0]        wr_addr_i,
  input  logic [TIER_BITS-1:0]                  tier_wdata_i,
  input  lbws_pkg::lbws_stat_t                  stat_wdata_i,
  input  lbws_pkg::lbws_dyn_t                   dyn_wdata_i,
  input  logic [$clog2(MAX_WORKERS+1)-1:0]      clr_cnt_i,
  input  logic [$clog2(MAX_WORKERS)-1:0]        rd_addr_i,
  output logic [TIER_BITS-1:0]                  rd_tier_o,
  output lbws_pkg::lbws_stat_t                  rd_stat_o,
  output lbws_pkg::lbws_dyn_t                   rd_dyn_o
);

  logic [TIER_BITS-1:0]  tier_mem [MAX_WORKERS];
  lbws_pkg::lbws_stat_t  stat_mem [MAX_WORKERS];
  lbws_pkg::lbws_dyn_t   dyn_mem  [MAX_WORKERS];

  logic [MAX_WORKERS-1:0] vld_stat_r, vld_stat_nxt;
  logic [MAX_WORKERS-1:0] vld_dyn_r, vld_dyn_nxt;
  logic                   rd_vs_r, rd_vd_r;
  logic [TIER_BITS-1:0]   rd_tier_q;
  lbws_pkg::lbws_stat_t   rd_stat_q;
  lbws_pkg::lbws_dyn_t    rd_dyn_q;

  always_ff @(posedge clk) begin
    if (wr_i.stat_we) begin
      tier_mem[wr_addr_i] <= tier_wdata_i;
      stat_mem[wr_addr_i] <= stat_wdata_i;
    end
    if (wr_i.dyn_we) begin
      dyn_mem[wr_addr_i] <= dyn_wdata_i;
    end
    rd_tier_q <= tier_mem[rd_addr_i];
    rd_stat_q <= stat_mem[rd_addr_i];
    rd_dyn_q  <= dyn_mem[rd_addr_i];
  end

  always_comb begin
    vld_stat_nxt = vld_stat_r;
    vld_dyn_nxt  = vld_dyn_r;
    if (wr_i.clr) begin
      for (int j = 0; j < MAX_WORKERS; j++) begin
        if (j < int'(clr_cnt_i)) begin
          vld_dyn_nxt[j] = 1'b0;
        end
      end
    end
    if (wr_i.stat_we) begin
      vld_stat_nxt[wr_addr_i] = 1'b1;
    end
    if (wr_i.dyn_we) begin
      vld_dyn_nxt[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_stat_r <= '0;
      vld_dyn_r  <= '0;
      rd_vs_r    <= 1'b0;
      rd_vd_r    <= 1'b0;
    end else begin
      vld_stat_r <= vld_stat_nxt;
      vld_dyn_r  <= vld_dyn_nxt;
      rd_vs_r    <= vld_stat_r[rd_addr_i];
      rd_vd_r    <= vld_dyn_r[rd_addr_i];
    end
  end

  assign rd_tier_o = rd_vs_r ? rd_tier_q : '0;
  assign rd_stat_o = rd_vs_r ? rd_stat_q : '0;
  assign rd_dyn_o  = rd_vd_r ? rd_dyn_q  : '0;

endmodule

@@ rtl/core/lbws_seq.sv @@
// Request sequencer: update read-modify-write, clear, and the select walk
// over rounds, tiers and passes. Depends on lbws_pkg and lbws_table.
module lbws_seq #(
  parameter int MAX_WORKERS = 16,
  parameter int TIER_BITS   = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  lbws_pkg::lbws_item_t             item_i,
  input  logic [$clog2(MAX_WORKERS+1)-1:0] n_i,
  output logic                             idle_o,
  output logic                             res_vld_o,
  input  logic                             res_rdy_i,
  output lbws_pkg::lbws_res_t              res_o
);

  localparam int IDX_W = $clog2(MAX_WORKERS);
  localparam int CNT_W = $clog2(MAX_WORKERS+1);

  lbws_pkg::lbws_state_t state_r, state_nxt;
  lbws_pkg::lbws_item_t  item_r, item_nxt;
  logic [CNT_W-1:0]      rd_i_r, rd_i_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic                  round_r, round_nxt;
  logic                  any_r, any_nxt;
  logic [TIER_BITS-1:0]  max_tier_r, max_tier_nxt;
  logic [TIER_BITS-1:0]  tier_r, tier_nxt;
  logic                  pass_r, pass_nxt;
  logic [lbws_pkg::STATUS_W-1:0] sum_r, sum_nxt;
  logic                  cand_vld_r, cand_vld_nxt;
  logic [IDX_W-1:0]      cand_idx_r, cand_idx_nxt;
  logic [lbws_pkg::BUSY_W-1:0]   cand_busy_r, cand_busy_nxt;
  logic [lbws_pkg::STATUS_W-1:0] cand_st_r, cand_st_nxt;

  lbws_pkg::lbws_wr_t    wr;
  logic [IDX_W-1:0]      wr_addr, rd_addr, slot_idx;
  logic [TIER_BITS-1:0]  tier_wdata, rd_tier;
  lbws_pkg::lbws_stat_t  stat_wdata, rd_stat;
  lbws_pkg::lbws_dyn_t   dyn_wdata, rd_dyn;

  logic [MAX_WORKERS-1:0] member;
  logic                   scanning, issue, scan_end, elig, better, slot_ok;
  logic [lbws_pkg::STATUS_W-1:0] new_st;

  lbws_table #(
    .MAX_WORKERS(MAX_WORKERS),
    .TIER_BITS  (TIER_BITS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .tier_wdata_i(tier_wdata),
    .stat_wdata_i(stat_wdata),
    .dyn_wdata_i (dyn_wdata),
    .clr_cnt_i   (n_i),
    .rd_addr_i   (rd_addr),
    .rd_tier_o   (rd_tier),
    .rd_stat_o   (rd_stat),
    .rd_dyn_o    (rd_dyn)
  );

  assign slot_idx = IDX_W'(item_r.worker_slot);
  assign slot_ok  = int'(item_i.worker_slot) < MAX_WORKERS;
  assign member   = round_r ? MAX_WORKERS'(item_r.allow_mask)
                            : MAX_WORKERS'(item_r.prefer_mask);
  assign scanning = (state_r == lbws_pkg::S_MAX) || (state_r == lbws_pkg::S_PASS);
  assign issue    = scanning && (rd_i_r < n_i);
  assign scan_end = scanning && !(rd_i_r < n_i) && !ev_vld_r;
  assign rd_addr  = (state_r == lbws_pkg::S_UPD_RD) ? slot_idx : rd_i_r[IDX_W-1:0];
  assign new_st   = rd_dyn.status + lbws_pkg::STATUS_W'(rd_stat.weight);
  assign elig     = ev_vld_r && member[ev_idx_r] && (rd_tier == tier_r) &&
                    (rd_stat.standby == pass_r) && !rd_stat.draining && rd_stat.usable;
  assign better   = !cand_vld_r || (rd_dyn.busy < cand_busy_r) ||
                    ((rd_dyn.busy == cand_busy_r) && ($signed(new_st) > $signed(cand_st_r)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbws_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (item_i.req_type)
            lbws_pkg::REQ_UPDATE: state_nxt = slot_ok ? lbws_pkg::S_UPD_RD : lbws_pkg::S_IDLE;
            lbws_pkg::REQ_SELECT: state_nxt = lbws_pkg::S_MAX;
            lbws_pkg::REQ_RESET:  state_nxt = lbws_pkg::S_CLR;
            default:              state_nxt = lbws_pkg::S_IDLE;
          endcase
        end
      end
      lbws_pkg::S_UPD_RD: state_nxt = lbws_pkg::S_UPD_WR;
      lbws_pkg::S_UPD_WR: state_nxt = lbws_pkg::S_IDLE;
      lbws_pkg::S_CLR:    state_nxt = lbws_pkg::S_IDLE;
      lbws_pkg::S_MAX: begin
        if (scan_end) begin
          priority if (any_r)   state_nxt = lbws_pkg::S_PASS;
          else if (round_r)     state_nxt = lbws_pkg::S_OUT;
          else                  state_nxt = lbws_pkg::S_MAX;
        end
      end
      lbws_pkg::S_PASS: begin
        if (scan_end) begin
          priority if (cand_vld_r)                 state_nxt = lbws_pkg::S_FIN;
          else if (!pass_r)                        state_nxt = lbws_pkg::S_PASS;
          else if (tier_r == max_tier_r && round_r) state_nxt = lbws_pkg::S_OUT;
          else if (tier_r == max_tier_r)           state_nxt = lbws_pkg::S_MAX;
          else                                     state_nxt = lbws_pkg::S_PASS;
        end
      end
      lbws_pkg::S_FIN: state_nxt = lbws_pkg::S_OUT;
      lbws_pkg::S_OUT: begin
        if (res_rdy_i) begin
          state_nxt = lbws_pkg::S_IDLE;
        end
      end
      default: state_nxt = lbws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    rd_i_nxt      = rd_i_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    round_nxt     = round_r;
    any_nxt       = any_r;
    max_tier_nxt  = max_tier_r;
    tier_nxt      = tier_r;
    pass_nxt      = pass_r;
    sum_nxt       = sum_r;
    cand_vld_nxt  = cand_vld_r;
    cand_idx_nxt  = cand_idx_r;
    cand_busy_nxt = cand_busy_r;
    cand_st_nxt   = cand_st_r;
    wr            = '0;
    wr_addr       = ev_idx_r;
    tier_wdata    = TIER_BITS'(item_r.tier);
    stat_wdata    = '{weight:   item_r.weight,
                      standby:  item_r.is_standby,
                      draining: item_r.is_draining,
                      usable:   item_r.is_usable};
    dyn_wdata     = '{busy: rd_dyn.busy, status: new_st};
    res_vld_o     = 1'b0;

    if (issue) begin
      rd_i_nxt   = rd_i_r + CNT_W'(1);
      ev_vld_nxt = 1'b1;
      ev_idx_nxt = rd_i_r[IDX_W-1:0];
    end

    unique case (state_r)
      lbws_pkg::S_IDLE: begin
        if (start_i) begin
          item_nxt     = item_i;
          rd_i_nxt     = '0;
          round_nxt    = 1'b0;
          any_nxt      = 1'b0;
          max_tier_nxt = '0;
          cand_vld_nxt = 1'b0;
        end
      end
      lbws_pkg::S_UPD_RD: begin
      end
      lbws_pkg::S_UPD_WR: begin
        wr.stat_we = 1'b1;
        wr.dyn_we  = 1'b1;
        wr_addr    = slot_idx;
        dyn_wdata  = '{busy: item_r.busy_count, status: rd_dyn.status};
      end
      lbws_pkg::S_CLR: begin
        wr.clr = 1'b1;
      end
      lbws_pkg::S_MAX: begin
        if (ev_vld_r && member[ev_idx_r]) begin
          any_nxt      = 1'b1;
          max_tier_nxt = (rd_tier > max_tier_r) ? rd_tier : max_tier_r;
        end
        if (scan_end) begin
          rd_i_nxt = '0;
          if (any_r) begin
            tier_nxt     = '0;
            pass_nxt     = 1'b0;
            sum_nxt      = '0;
            cand_vld_nxt = 1'b0;
          end else if (!round_r) begin
            round_nxt    = 1'b1;
            max_tier_nxt = '0;
          end
        end
      end
      lbws_pkg::S_PASS: begin
        if (elig) begin
          wr.dyn_we = 1'b1;
          sum_nxt   = sum_r + lbws_pkg::STATUS_W'(rd_stat.weight);
          if (better) begin
            cand_vld_nxt  = 1'b1;
            cand_idx_nxt  = ev_idx_r;
            cand_busy_nxt = rd_dyn.busy;
            cand_st_nxt   = new_st;
          end
        end
        if (scan_end) begin
          rd_i_nxt = '0;
          priority if (cand_vld_r) begin
          end else if (!pass_r) begin
            pass_nxt = 1'b1;
          end else if (tier_r == max_tier_r) begin
            round_nxt    = 1'b1;
            any_nxt      = 1'b0;
            max_tier_nxt = '0;
          end else begin
            tier_nxt = tier_r + TIER_BITS'(1);
            pass_nxt = 1'b0;
          end
        end
      end
      lbws_pkg::S_FIN: begin
        wr.dyn_we   = 1'b1;
        wr_addr     = cand_idx_r;
        dyn_wdata   = '{busy: cand_busy_r, status: cand_st_r - sum_r};
        cand_st_nxt = cand_st_r - sum_r;
      end
      lbws_pkg::S_OUT: begin
        res_vld_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_r == lbws_pkg::S_IDLE);
  assign res_o  = '{found:  cand_vld_r,
                    worker: cand_vld_r ? lbws_pkg::SLOT_W'(cand_idx_r) : '0,
                    status: cand_vld_r ? cand_st_r : '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lbws_pkg::S_IDLE;
      ev_vld_r   <= 1'b0;
      cand_vld_r <= 1'b0;
      round_r    <= 1'b0;
      any_r      <= 1'b0;
      pass_r     <= 1'b0;
      rd_i_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      ev_vld_r   <= ev_vld_nxt;
      cand_vld_r <= cand_vld_nxt;
      round_r    <= round_nxt;
      any_r      <= any_nxt;
      pass_r     <= pass_nxt;
      rd_i_r     <= rd_i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    ev_idx_r    <= ev_idx_nxt;
    max_tier_r  <= max_tier_nxt;
    tier_r      <= tier_nxt;
    sum_r       <= sum_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_busy_r <= cand_busy_nxt;
    cand_st_r   <= cand_st_nxt;
  end

  a_dyn_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.dyn_we |-> (state_r == lbws_pkg::S_PASS || state_r == lbws_pkg::S_FIN ||
                   state_r == lbws_pkg::S_UPD_WR))
    else $error("busy/status write outside a writing state");

  a_fin_has_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbws_pkg::S_FIN) |-> cand_vld_r)
    else $error("final write without a candidate");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbws_pkg::S_FIN) |=> (state_r == lbws_pkg::S_OUT))
    else $error("final write not followed by result");

  a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbws_pkg::S_UPD_WR) |-> ($past(state_r) == lbws_pkg::S_UPD_RD))
    else $error("update write without prior read");

endmodule

@@ rtl/core/least_busy_worker_select_top.sv @@
// Least-busy worker selector, top level: handshakes, active-count register,
// result register. Depends on lbws_pkg, lbws_seq and lbws_table.
// Update reads the entry and then writes it; busy/status reset clears the active entries.
// Select: per round a tier scan, then the passes of each tier (up to two passes per tier
//   up to the highest member tier), a final write if a worker was found, and the result.
// One item at a time; active entries are each visited once per pass via the memory read port.
// Reset clears valid bits, so the table reads as zero at once; active count resets to 16.
module least_busy_worker_select_top #(
  parameter int MAX_WORKERS = 16,
  parameter int TIER_BITS   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [3:0]          in_worker_slot,
  input  logic [3:0]          in_tier,
  input  logic [7:0]          in_weight,
  input  logic [15:0]         in_busy_count,
  input  logic                in_is_standby,
  input  logic                in_is_draining,
  input  logic                in_is_usable,
  input  logic [15:0]         in_prefer_mask,
  input  logic [15:0]         in_allow_mask,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [3:0]          out_chosen_worker,
  output logic signed [31:0]  out_chosen_status,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_WORKERS+1);

  logic [lbws_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic [CNT_W-1:0]              n_cnt;
  lbws_pkg::lbws_item_t          item;
  lbws_pkg::lbws_res_t           res, res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          idle, start, res_vld, res_rdy;

  assign item = '{req_type:    lbws_pkg::lbws_req_t'(in_req_type),
                  worker_slot: in_worker_slot,
                  tier:        in_tier,
                  weight:      in_weight,
                  busy_count:  in_busy_count,
                  is_standby:  in_is_standby,
                  is_draining: in_is_draining,
                  is_usable:   in_is_usable,
                  prefer_mask: in_prefer_mask,
                  allow_mask:  in_allow_mask};

  assign in_stall = !idle;
  assign start    = in_valid && idle;
  assign n_cnt    = (int'(active_r) > MAX_WORKERS) ? CNT_W'(MAX_WORKERS) : CNT_W'(active_r);
  assign res_rdy  = !out_valid_r || !out_stall;

  lbws_seq #(
    .MAX_WORKERS(MAX_WORKERS),
    .TIER_BITS  (TIER_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .item_i   (item),
    .n_i      (n_cnt),
    .idle_o   (idle),
    .res_vld_o(res_vld),
    .res_rdy_i(res_rdy),
    .res_o    (res)
  );

  always_comb begin
    active_nxt    = cfg_wr_en ? cfg_wr_data : active_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (res_vld && res_rdy) begin
      res_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= lbws_pkg::ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = res_r.found;
  assign out_chosen_worker = res_r.worker;
  assign out_chosen_status = $signed(res_r.status);

endmodule
